FILE: rtl/lsms_pkg.sv
// package for the scanline mode sequencer
// holds the mode encoding, register indexes, field widths and reset values
// no dependencies
package lsms_pkg;

    localparam int unsigned DotWidth  = 9;
    localparam int unsigned LineWidth = 8;
    localparam int unsigned CfgIdxWidth  = 3;
    localparam int unsigned CfgDataWidth = 9;

    localparam logic [DotWidth-1:0] DotMax = 9'd511;

    typedef enum logic [1:0] {
        MODE_HBLANK   = 2'd0,
        MODE_VBLANK   = 2'd1,
        MODE_SEARCH   = 2'd2,
        MODE_TRANSFER = 2'd3
    } mode_t;

    typedef enum logic [CfgIdxWidth-1:0] {
        REG_SEARCH_CYCLES     = 3'd0,
        REG_TRANSFER_CYCLES   = 3'd1,
        REG_HBLANK_CYCLES     = 3'd2,
        REG_LINE_PERIOD       = 3'd3,
        REG_VBLANK_START_LINE = 3'd4,
        REG_FINAL_LINE        = 3'd5
    } cfg_index_t;

    localparam logic [DotWidth-1:0]  SearchCyclesReset    = 9'd80;
    localparam logic [DotWidth-1:0]  TransferCyclesReset  = 9'd172;
    localparam logic [DotWidth-1:0]  HblankCyclesReset    = 9'd204;
    localparam logic [DotWidth-1:0]  LinePeriodReset      = 9'd456;
    localparam logic [LineWidth-1:0] VblankStartLineReset = 8'd144;
    localparam logic [LineWidth-1:0] FinalLineReset       = 8'd153;

    typedef struct packed {
        logic vblank_irq;
        logic line_changed;
        logic scanline_done;
    } strobe_t;

endpackage

FILE: rtl/lcd_scanline_mode_sequencer.sv
// scanline mode sequencer for a display controller: dot and line timing
// depends on lsms_pkg for the mode encoding, register indexes and reset values
//
// usage:
//   input channel: in_valid / in_stall carry one advance bit per transfer.
//   advance = 1 moves the timing on by one dot, advance = 0 holds the timing state.
//   output channel: out_valid / out_stall carry mode, line and the three
//   strobes (vblank_irq, line_changed, scanline_done) for every input transfer.
//   config channel: cfg_valid / cfg_ready with cfg_index and cfg_data; cfg_ready
//   is always high, write only while no transfer is in flight.
//   output: the result is registered and appears in the cycle after the input transfer.
//   throughput: one item per cycle while in_stall is low; the mode, dot and line
//   registers update in the same cycle as the transfer, so the next item can follow directly.
//   stall: a full result register holds while out_stall is high; in_stall goes
//   high only when that register is full and stalled, so a new item is taken
//   in the same cycle as the held result leaves.
//   reset: sprite search mode, dot and line counters at zero, all timing
//   registers at their defaults, output register empty.
module lcd_scanline_mode_sequencer
(
    input  logic                              clk,
    input  logic                              rst_n,

    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              advance,

    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [1:0]                        mode,
    output logic [lsms_pkg::LineWidth-1:0]    line,
    output logic                              vblank_irq,
    output logic                              line_changed,
    output logic                              scanline_done,

    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [lsms_pkg::CfgIdxWidth-1:0]  cfg_index,
    input  logic [lsms_pkg::CfgDataWidth-1:0] cfg_data
);

    logic [lsms_pkg::DotWidth-1:0]  search_cycles_reg;
    logic [lsms_pkg::DotWidth-1:0]  transfer_cycles_reg;
    logic [lsms_pkg::DotWidth-1:0]  hblank_cycles_reg;
    logic [lsms_pkg::DotWidth-1:0]  line_period_reg;
    logic [lsms_pkg::LineWidth-1:0] vblank_start_line_reg;
    logic [lsms_pkg::LineWidth-1:0] final_line_reg;

    lsms_pkg::mode_t                mode_reg, mode_next;
    logic [lsms_pkg::DotWidth-1:0]  dot_reg, dot_next;
    logic [lsms_pkg::LineWidth-1:0] line_reg, line_next;

    logic                           out_valid_reg;
    lsms_pkg::mode_t                out_mode_reg;
    logic [lsms_pkg::LineWidth-1:0] out_line_reg;
    lsms_pkg::strobe_t              out_strobe_reg, strobe_next;

    logic                           in_xfer;
    logic [lsms_pkg::DotWidth-1:0]  dot_inc;
    logic                           cfg_write;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid & cfg_ready;

    assign in_stall = out_valid_reg & out_stall;
    assign in_xfer  = in_valid & ~in_stall;

    // saturating dot count
    assign dot_inc = (dot_reg == lsms_pkg::DotMax) ? dot_reg
                                                   : dot_reg + lsms_pkg::DotWidth'(1);

    // next state of the timing sequencer
    always_comb
    begin
        mode_next = mode_reg;
        dot_next  = dot_reg;
        line_next = line_reg;
        if (advance)
        begin
            dot_next = dot_inc;
            unique case (mode_reg)
                lsms_pkg::MODE_TRANSFER:
                begin
                    if (dot_inc >= transfer_cycles_reg)
                    begin
                        mode_next = lsms_pkg::MODE_HBLANK;
                        dot_next  = '0;
                    end
                end
                lsms_pkg::MODE_VBLANK:
                begin
                    // frame restart takes priority over the line period
                    if (line_reg == final_line_reg)
                    begin
                        mode_next = lsms_pkg::MODE_SEARCH;
                        line_next = '0;
                        dot_next  = '0;
                    end
                    else if (dot_inc >= line_period_reg)
                    begin
                        line_next = line_reg + lsms_pkg::LineWidth'(1);
                        dot_next  = '0;
                    end
                end
                lsms_pkg::MODE_HBLANK:
                begin
                    if (dot_inc >= hblank_cycles_reg)
                    begin
                        mode_next = (line_reg == vblank_start_line_reg)
                                    ? lsms_pkg::MODE_VBLANK : lsms_pkg::MODE_SEARCH;
                        line_next = line_reg + lsms_pkg::LineWidth'(1);
                        dot_next  = '0;
                    end
                end
                lsms_pkg::MODE_SEARCH:
                begin
                    if (dot_inc >= search_cycles_reg)
                    begin
                        mode_next = lsms_pkg::MODE_TRANSFER;
                        dot_next  = '0;
                    end
                end
            endcase
        end
    end

    // strobes for this tick
    always_comb
    begin
        strobe_next = '0;
        if (advance)
        begin
            unique case (mode_reg)
                lsms_pkg::MODE_TRANSFER:
                begin
                    strobe_next.scanline_done = (dot_inc >= transfer_cycles_reg);
                end
                lsms_pkg::MODE_VBLANK:
                begin
                    strobe_next.line_changed = (line_reg != final_line_reg) &&
                                               (dot_inc >= line_period_reg);
                end
                lsms_pkg::MODE_HBLANK:
                begin
                    strobe_next.line_changed = (dot_inc >= hblank_cycles_reg);
                    strobe_next.vblank_irq   = (dot_inc >= hblank_cycles_reg) &&
                                               (line_reg == vblank_start_line_reg);
                end
                lsms_pkg::MODE_SEARCH:
                begin
                    strobe_next = '0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            search_cycles_reg     <= lsms_pkg::SearchCyclesReset;
            transfer_cycles_reg   <= lsms_pkg::TransferCyclesReset;
            hblank_cycles_reg     <= lsms_pkg::HblankCyclesReset;
            line_period_reg       <= lsms_pkg::LinePeriodReset;
            vblank_start_line_reg <= lsms_pkg::VblankStartLineReset;
            final_line_reg        <= lsms_pkg::FinalLineReset;
        end
        else if (cfg_write)
        begin
            unique case (lsms_pkg::cfg_index_t'(cfg_index))
                lsms_pkg::REG_SEARCH_CYCLES:     search_cycles_reg   <= cfg_data;
                lsms_pkg::REG_TRANSFER_CYCLES:   transfer_cycles_reg <= cfg_data;
                lsms_pkg::REG_HBLANK_CYCLES:     hblank_cycles_reg   <= cfg_data;
                lsms_pkg::REG_LINE_PERIOD:       line_period_reg     <= cfg_data;
                lsms_pkg::REG_VBLANK_START_LINE:
                    vblank_start_line_reg <= cfg_data[lsms_pkg::LineWidth-1:0];
                lsms_pkg::REG_FINAL_LINE:
                    final_line_reg <= cfg_data[lsms_pkg::LineWidth-1:0];
                default:
                begin
                    // writes beyond the register list are dropped
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= lsms_pkg::MODE_SEARCH;
            dot_reg       <= '0;
            line_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_xfer)
            begin
                mode_reg      <= mode_next;
                dot_reg       <= dot_next;
                line_reg      <= line_next;
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result register, no reset needed on payload
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            out_mode_reg   <= mode_next;
            out_line_reg   <= line_next;
            out_strobe_reg <= strobe_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign mode          = out_mode_reg;
    assign line          = out_line_reg;
    assign vblank_irq    = out_strobe_reg.vblank_irq;
    assign line_changed  = out_strobe_reg.line_changed;
    assign scanline_done = out_strobe_reg.scanline_done;

endmodule

FILE: tb/sv/tb_lcd_scanline_mode_sequencer.sv
// testbench for lcd_scanline_mode_sequencer: random and directed dot ticks under random idling
// depends on lsms_pkg and the sequencer rtl; self-contained scoreboard predicts every result
`timescale 1ns / 100ps

module tb_lcd_scanline_mode_sequencer;

    typedef struct packed {
        logic [1:0]                     mode;
        logic [lsms_pkg::LineWidth-1:0] line;
        logic                           irq;
        logic                           changed;
        logic                           done;
    } scan_out_t;

    class timing_scoreboard;
        logic [lsms_pkg::DotWidth-1:0]  search_len;
        logic [lsms_pkg::DotWidth-1:0]  transfer_len;
        logic [lsms_pkg::DotWidth-1:0]  hblank_len;
        logic [lsms_pkg::DotWidth-1:0]  vblank_period;
        logic [lsms_pkg::LineWidth-1:0] vblank_line;
        logic [lsms_pkg::LineWidth-1:0] last_line;

        lsms_pkg::mode_t                cur_mode;
        logic [lsms_pkg::DotWidth-1:0]  dots;
        logic [lsms_pkg::LineWidth-1:0] line_no;

        scan_out_t                      pending_outputs[$];
        int                             errors;

        function new();
            search_len    = lsms_pkg::SearchCyclesReset;
            transfer_len  = lsms_pkg::TransferCyclesReset;
            hblank_len    = lsms_pkg::HblankCyclesReset;
            vblank_period = lsms_pkg::LinePeriodReset;
            vblank_line   = lsms_pkg::VblankStartLineReset;
            last_line     = lsms_pkg::FinalLineReset;
            cur_mode      = lsms_pkg::MODE_SEARCH;
            dots          = '0;
            line_no       = '0;
            errors        = 0;
        endfunction

        function void write_reg(lsms_pkg::cfg_index_t idx,
                                logic [lsms_pkg::CfgDataWidth-1:0] data);
            unique case (idx)
                lsms_pkg::REG_SEARCH_CYCLES:     search_len    = data;
                lsms_pkg::REG_TRANSFER_CYCLES:   transfer_len  = data;
                lsms_pkg::REG_HBLANK_CYCLES:     hblank_len    = data;
                lsms_pkg::REG_LINE_PERIOD:       vblank_period = data;
                lsms_pkg::REG_VBLANK_START_LINE:
                    vblank_line = data[lsms_pkg::LineWidth-1:0];
                lsms_pkg::REG_FINAL_LINE:
                    last_line = data[lsms_pkg::LineWidth-1:0];
                default: ;
            endcase
        endfunction

        // advance the dot/line timing by one accepted tick and queue the outcome
        function void note_tick(logic adv);
            scan_out_t r;
            r = '0;
            if (adv)
            begin
                if (dots < lsms_pkg::DotMax)
                    dots = dots + 1'b1;
                unique case (cur_mode)
                    lsms_pkg::MODE_TRANSFER:
                    begin
                        if (dots >= transfer_len)
                        begin
                            cur_mode = lsms_pkg::MODE_HBLANK;
                            dots     = '0;
                            r.done   = 1'b1;
                        end
                    end
                    lsms_pkg::MODE_VBLANK:
                    begin
                        // frame restart wins over the period test and is not an increment
                        if (line_no == last_line)
                        begin
                            cur_mode = lsms_pkg::MODE_SEARCH;
                            line_no  = '0;
                            dots     = '0;
                        end
                        else if (dots >= vblank_period)
                        begin
                            line_no   = line_no + 1'b1;
                            dots      = '0;
                            r.changed = 1'b1;
                        end
                    end
                    lsms_pkg::MODE_HBLANK:
                    begin
                        if (dots >= hblank_len)
                        begin
                            if (line_no == vblank_line)
                            begin
                                cur_mode = lsms_pkg::MODE_VBLANK;
                                r.irq    = 1'b1;
                            end
                            else
                                cur_mode = lsms_pkg::MODE_SEARCH;
                            line_no   = line_no + 1'b1;
                            dots      = '0;
                            r.changed = 1'b1;
                        end
                    end
                    default:
                    begin
                        if (dots >= search_len)
                        begin
                            cur_mode = lsms_pkg::MODE_TRANSFER;
                            dots     = '0;
                        end
                    end
                endcase
            end
            r.mode = cur_mode;
            r.line = line_no;
            pending_outputs.push_back(r);
        endfunction

        function void check_result(logic [1:0] m, logic [lsms_pkg::LineWidth-1:0] l,
                                   logic irq, logic chg, logic done);
            scan_out_t e;
            if (pending_outputs.size() == 0)
            begin
                $error("result transfer with nothing outstanding");
                errors++;
                return;
            end
            e = pending_outputs.pop_front();
            if (m !== e.mode)
            begin
                $error("mode: expected %0d, got %0d", e.mode, m);
                errors++;
            end
            if (l !== e.line)
            begin
                $error("line: expected %0d, got %0d", e.line, l);
                errors++;
            end
            if (irq !== e.irq)
            begin
                $error("vblank_irq: expected %0d, got %0d", e.irq, irq);
                errors++;
            end
            if (chg !== e.changed)
            begin
                $error("line_changed: expected %0d, got %0d", e.changed, chg);
                errors++;
            end
            if (done !== e.done)
            begin
                $error("scanline_done: expected %0d, got %0d", e.done, done);
                errors++;
            end
        endfunction

        function int pending();
            return pending_outputs.size();
        endfunction
    endclass

    logic                              clk          = 1'b0;
    logic                              rst_n        = 1'b0;
    logic                              in_valid     = 1'b0;
    logic                              in_stall;
    logic                              advance      = 1'b0;
    logic                              out_valid;
    logic                              out_stall    = 1'b0;
    logic [1:0]                        mode;
    logic [lsms_pkg::LineWidth-1:0]    line;
    logic                              vblank_irq;
    logic                              line_changed;
    logic                              scanline_done;
    logic                              cfg_valid    = 1'b0;
    logic                              cfg_ready;
    logic [lsms_pkg::CfgIdxWidth-1:0]  cfg_index    = '0;
    logic [lsms_pkg::CfgDataWidth-1:0] cfg_data     = '0;

    logic                              steady       = 1'b0;
    timing_scoreboard                  sb           = new();

    lcd_scanline_mode_sequencer i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .advance       (advance),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .mode          (mode),
        .line          (line),
        .vblank_irq    (vblank_irq),
        .line_changed  (line_changed),
        .scanline_done (scanline_done),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(negedge clk)
        out_stall <= steady ? 1'b0 : ($urandom_range(0, 99) < 37);

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(mode, line, vblank_irq, line_changed, scanline_done);
    end

    initial
    begin
        #2ms;
        $display("== FAIL ==");
        $finish;
    end

    // one tick transfer; entered and left at a falling edge
    task automatic send_tick(input logic adv);
        while (!steady && $urandom_range(0, 99) < 37)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        advance  <= adv;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_tick(adv);
        @(negedge clk);
    endtask

    task automatic run_ticks(input int count, input int pct_advance);
        for (int n = 0; n < count; n++)
            send_tick($urandom_range(0, 99) < pct_advance);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
    endtask

    // write all six timing registers, lowest index first
    task automatic set_timing(input logic [lsms_pkg::CfgDataWidth-1:0] s, t, h, p, vs, fl);
        logic [lsms_pkg::CfgDataWidth-1:0] vals [6];
        vals = '{s, t, h, p, vs, fl};
        for (int i = 0; i < 6; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= lsms_pkg::cfg_index_t'(i);
            cfg_data  <= vals[i];
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            sb.write_reg(lsms_pkg::cfg_index_t'(i), vals[i]);
            @(negedge clk);
        end
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [lsms_pkg::CfgDataWidth-1:0] line_reg(int value);
        // upper data bit is ignored by the 8-bit registers, so toggle it freely
        return {1'($urandom_range(0, 1)), 8'(value)};
    endfunction

    initial
    begin
        logic dir_ticks [20];
        int   vs;
        dir_ticks = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0,
                      1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1};

        repeat (9) @(negedge clk);
        rst_n <= 1'b1;

        // reset timing: a few holds and advances in sprite search
        send_tick(1'b0);
        send_tick(1'b1);
        send_tick(1'b1);
        send_tick(1'b1);
        send_tick(1'b0);
        drain();

        // short lengths: search ends at once since the count already exceeds it,
        // then one full line into vblank with irq, a vblank line and a frame restart
        set_timing(9'd2, 9'd1, 9'd3, 9'd2, line_reg(0), line_reg(2));
        foreach (dir_ticks[k])
            send_tick(dir_ticks[k]);
        drain();

        // climb to line 254 with minimum lengths, then vblank across the line wrap
        set_timing(9'd1, 9'd1, 9'd1, 9'd1, line_reg(254), line_reg(1));
        steady = 1'b1;
        run_ticks(300, 96);
        steady = 1'b0;
        run_ticks(550, 96);
        drain();

        // largest lengths and line registers
        set_timing(9'd511, 9'd511, 9'd511, 9'd511, line_reg(255), line_reg(255));
        run_ticks(100, 85);
        drain();

        // smallest settings: lengths end right away, vblank ends on the next tick
        set_timing(9'd1, 9'd1, 9'd1, 9'd1, line_reg(0), line_reg(1));
        run_ticks(40, 85);
        drain();

        repeat (7)
        begin
            vs = $urandom_range(0, 6);
            set_timing(9'($urandom_range(1, 5)), 9'($urandom_range(1, 5)),
                       9'($urandom_range(1, 5)), 9'($urandom_range(1, 4)),
                       line_reg(vs), line_reg(vs + $urandom_range(1, 3)));
            run_ticks(60, 85);
            drain();
        end

        repeat (4) @(negedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

FILE: sim.f
rtl/lsms_pkg.sv
rtl/lcd_scanline_mode_sequencer.sv
tb/sv/tb_lcd_scanline_mode_sequencer.sv
